[hw/rtl/scci_pkg.sv]
// Shared types, status codes, rounding and saturation helpers for the
// sphere/cylinder coaxial intersection unit. No dependencies.
package scci_pkg;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;
  localparam logic [30:0] TOL_RESET = 31'd66;

  localparam logic [2:0] ST_BAD_RAD   = 3'd0;
  localparam logic [2:0] ST_ZERO_AXIS = 3'd1;
  localparam logic [2:0] ST_OFF_AXIS  = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_CIRCLE    = 3'd4;

  typedef struct packed {
    logic [2:0][31:0] sc;
    logic [31:0]      rs;
    logic [2:0][31:0] co;
    logic [2:0][31:0] ax;
    logic [31:0]      rc;
  } raw_item_t;

  typedef struct packed {
    logic             ok;
    logic [2:0]       status;
    logic [2:0][31:0] sc;
    logic [2:0][31:0] co;
    logic [2:0]       sgn;
    logic [2:0][31:0] m;
    logic [31:0]      rs;
    logic [31:0]      rc;
  } front_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0][31:0] cen;
    logic [2:0][17:0] nrm;
    logic [30:0]      rad;
    logic             last;
  } result_t;

  // Divide by 2^16, rounding half away from zero.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic [63:0] a;
    logic [63:0] q;
    a = x[63] ? (~x + 64'd1) : x;
    q = (a + 64'd32768) >> 16;
    return x[63] ? $signed(~q + 64'd1) : $signed(q);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

endpackage

[hw/rtl/scci_queue.sv]
// Small register-based queue used between the front and back and for results.
// Depends on nothing.
module scci_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = mem[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end
endmodule

[hw/rtl/scci_front.sv]
// Front stage: takes input beats, rejects bad radii and a zero axis, and
// pre-scales the axis magnitudes. Depends on scci_pkg.
module scci_front
  import scci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  raw_item_t   raw,
  output logic        out_valid,
  input  logic        out_ready,
  output front_item_t item
);
  logic        valid;
  front_item_t cls;
  logic [2:0][31:0] mag;
  logic [31:0] mx;
  logic [4:0]  msb;
  logic [4:0]  sh;
  logic        bad;
  logic        zero;

  always_comb begin
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = raw.ax[i][31] ? (~raw.ax[i] + 32'd1) : raw.ax[i];
      if (mag[i] > mx) mx = mag[i];
    end
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx[b]) msb = 5'(b);
    end
    sh   = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
    bad  = ($signed(raw.rs) <= 32'sd0) || ($signed(raw.rc) <= 32'sd0);
    zero = (mx == '0);
    cls.ok     = !bad && !zero;
    cls.status = bad ? ST_BAD_RAD : ST_ZERO_AXIS;
    cls.sc     = raw.sc;
    cls.co     = raw.co;
    cls.rs     = raw.rs;
    cls.rc     = raw.rc;
    for (int i = 0; i < 3; i++) begin
      cls.sgn[i] = raw.ax[i][31];
      cls.m[i]   = mag[i] << sh;
    end
  end

  assign full      = valid && !out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      item <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push && !full) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end
endmodule

[hw/rtl/scci_isqrt.sv]
// Iterative 64-bit integer square root, one result bit per cycle.
// Depends on nothing.
module scci_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root,
  output logic [32:0] rem
);
  logic        run;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitreg;
  logic [63:0] sum;

  assign sum  = r + bitreg;
  assign root = r[31:0];
  assign rem  = v[32:0];

  always_ff @(posedge clk) begin
    if (start) begin
      v      <= val;
      r      <= '0;
      bitreg <= 64'd1 << 62;
    end else if (run) begin
      if (v >= sum) begin
        v <= v - sum;
        r <= (r >> 1) + bitreg;
      end else begin
        r <= r >> 1;
      end
      bitreg <= bitreg >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
    end else if (run && bitreg == 64'd1) begin
      run  <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end
endmodule

[hw/rtl/scci_back.sv]
// Back end: sequencer that normalizes the axis, tests coaxiality and emits
// the result beats. Depends on scci_pkg and scci_isqrt.
module scci_back
  import scci_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] tol,
  input  logic        mid_empty,
  output logic        mid_pop,
  input  front_item_t mid,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res
);
  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001, S_SQ   = 17'h00002, S_LSTART = 17'h00004,
    S_LEN    = 17'h00008, S_DIV  = 17'h00010, S_DOT    = 17'h00020,
    S_ALONG  = 17'h00040, S_RADP = 17'h00080, S_RADQ   = 17'h00100,
    S_CHK    = 17'h00200, S_DISC = 17'h00400, S_THR    = 17'h00800,
    S_DCMP   = 17'h01000, S_H    = 17'h02000, S_CENP   = 17'h04000,
    S_OUT    = 17'h08000, S_EMIT = 17'h10000
  } state_t;

  state_t state;
  logic [1:0]  idx;
  logic [4:0]  it;
  logic [31:0] sc [3];
  logic [31:0] co [3];
  logic [31:0] m [3];
  logic [2:0]  sgn;
  logic [31:0] rs;
  logic [31:0] rc;
  logic [2:0]  st;
  logic [63:0] acc;
  logic [31:0] len;
  logic [48:0] drem;
  logic [16:0] q;
  logic signed [17:0] nrm [3];
  logic signed [52:0] dot;
  logic signed [37:0] along;
  logic signed [55:0] prod;
  logic        off;
  logic [61:0] p1;
  logic signed [63:0] disc;
  logic signed [63:0] thr;
  logic [32:0] h;
  logic        pass;
  logic        lastflag;
  logic signed [56:0] cprod [3];

  logic        sq_start;
  logic [63:0] sq_val;
  logic        sq_done;
  logic [31:0] sq_root;
  logic [32:0] sq_rem;

  logic signed [32:0] d_sel;
  logic [48:0] dvs;
  logic        ge;
  logic [16:0] qfin;
  logic signed [41:0] r_rad;
  logic [41:0] r_abs;
  logic        one_circle;
  logic signed [38:0] vv;
  logic signed [63:0] cs [3];

  scci_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(sq_val),
    .done(sq_done), .root(sq_root), .rem(sq_rem)
  );

  assign d_sel = $signed({sc[idx][31], sc[idx]}) - $signed({co[idx][31], co[idx]});
  assign dvs   = 49'(len) << it;
  assign ge    = (drem >= dvs);
  assign qfin  = {q[15:0], ge};
  assign r_rad = 42'(d_sel) - 42'(rnd16(64'(prod)));
  assign r_abs = r_rad[41] ? (~r_rad + 42'd1) : r_rad;
  assign one_circle = (h <= {2'b0, tol});
  assign vv = pass ? 39'(along) + $signed({6'b0, h})
                   : (one_circle ? 39'(along) : 39'(along) - $signed({6'b0, h}));

  assign sq_start = (state == S_LSTART) ||
                    (state == S_DCMP && !(disc < -thr) &&
                     !(disc <= $signed({17'b0, tol, 16'b0})));
  assign sq_val   = (state == S_DCMP) ? disc : acc;
  assign mid_pop  = (state == S_IDLE) && !mid_empty;
  assign res_push = ((state == S_OUT) || (state == S_EMIT)) && !res_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs[i] = 64'($signed(co[i])) + rnd16(64'(cprod[i]));
      res.nrm[i] = nrm[i];
      res.cen[i] = (state == S_OUT) ? sat32(cs[i]) : 32'd0;
    end
    res.status = (state == S_OUT) ? ST_CIRCLE : st;
    res.rad    = (state == S_OUT) ? rc[30:0] : 31'd0;
    res.last   = (state == S_OUT) ? lastflag : 1'b1;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!mid_empty) begin
          for (int i = 0; i < 3; i++) begin
            sc[i]  <= mid.sc[i];
            co[i]  <= mid.co[i];
            m[i]   <= mid.m[i];
            nrm[i] <= '0;
          end
          sgn <= mid.sgn;
          rs  <= mid.rs;
          rc  <= mid.rc;
          st  <= mid.status;
          acc <= '0;
          idx <= '0;
        end
      end
      S_SQ: begin
        acc <= acc + 64'(m[idx]) * 64'(m[idx]);
        idx <= idx + 2'd1;
      end
      S_LSTART: begin
      end
      S_LEN: begin
        if (sq_done) begin
          len  <= sq_root;
          idx  <= '0;
          it   <= 5'd16;
          drem <= {1'b0, m[0], 16'b0} + 49'(sq_root >> 1);
        end
      end
      S_DIV: begin
        q <= qfin;
        // The last step of a component loads the next dividend instead.
        if (it == '0 && idx != 2'd2) begin
          drem <= {1'b0, m[idx + 2'd1], 16'b0} + 49'(len >> 1);
        end else if (ge) begin
          drem <= drem - dvs;
        end
        if (it == '0) begin
          nrm[idx] <= sgn[idx] ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});
          it <= 5'd16;
          idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
          dot <= '0;
        end else begin
          it <= it - 5'd1;
        end
      end
      S_DOT: begin
        dot <= dot + 53'(d_sel) * 53'(nrm[idx]);
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      S_ALONG: begin
        along <= 38'(rnd16(64'(dot)));
        acc   <= '0;
        off   <= 1'b0;
        idx   <= '0;
      end
      S_RADP: begin
        prod <= 56'(nrm[idx]) * 56'(along);
      end
      S_RADQ: begin
        if (|r_abs[41:31]) begin
          off <= 1'b1;
        end else begin
          acc <= acc + 64'(r_abs[30:0]) * 64'(r_abs[30:0]);
        end
        idx <= idx + 2'd1;
      end
      S_CHK: begin
        if (off || acc > 64'(tol) * 64'(tol)) begin
          st <= ST_OFF_AXIS;
        end else if ($signed(34'(rs)) + $signed({3'b0, tol}) < $signed(34'(rc))) begin
          st <= ST_EMPTY;
        end
        p1 <= 62'(rs[30:0]) * 62'(rs[30:0]);
      end
      S_DISC: begin
        disc <= $signed({2'b0, p1}) - $signed(64'(rc[30:0]) * 64'(rc[30:0]));
      end
      S_THR: begin
        thr <= $signed(64'(tol)) * (64'($signed(rs)) + 64'sd65536);
      end
      S_DCMP: begin
        if (disc < -thr) begin
          st <= ST_EMPTY;
        end
        h    <= '0;
        pass <= 1'b0;
      end
      S_H: begin
        if (sq_done) begin
          h <= {1'b0, sq_root} + 33'(sq_rem > {1'b0, sq_root});
        end
      end
      S_CENP: begin
        for (int i = 0; i < 3; i++) begin
          cprod[i] <= 57'(nrm[i]) * 57'(vv);
        end
        lastflag <= pass || one_circle;
      end
      S_OUT: begin
        if (!res_full) pass <= 1'b1;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!mid_empty) state <= mid.ok ? S_SQ : S_EMIT;
        end
        S_SQ:     if (idx == 2'd2) state <= S_LSTART;
        S_LSTART: state <= S_LEN;
        S_LEN:    if (sq_done) state <= S_DIV;
        S_DIV:    if (it == '0 && idx == 2'd2) state <= S_DOT;
        S_DOT:    if (idx == 2'd2) state <= S_ALONG;
        S_ALONG:  state <= S_RADP;
        S_RADP:   state <= S_RADQ;
        S_RADQ:   state <= (idx == 2'd2) ? S_CHK : S_RADP;
        S_CHK: begin
          if (off || acc > 64'(tol) * 64'(tol)) begin
            state <= S_EMIT;
          end else if ($signed(34'(rs)) + $signed({3'b0, tol}) < $signed(34'(rc))) begin
            state <= S_EMIT;
          end else begin
            state <= S_DISC;
          end
        end
        S_DISC:   state <= S_THR;
        S_THR:    state <= S_DCMP;
        S_DCMP: begin
          if (disc < -thr) state <= S_EMIT;
          else if (sq_start) state <= S_H;
          else state <= S_CENP;
        end
        S_H:      if (sq_done) state <= S_CENP;
        S_CENP:   state <= S_OUT;
        S_OUT:    if (!res_full) state <= lastflag ? S_IDLE : S_CENP;
        S_EMIT:   if (!res_full) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/sphere_cylinder_coaxial_intersect_unit.sv]
// Top level of the sphere/cylinder coaxial intersection unit.
// Depends on scci_pkg, scci_queue, scci_front and scci_back.
//
// Input channel: a beat carries one sphere and one cylinder; it is taken at
// a rising edge with push high and full low. The front stage classifies it
// (bad radius, zero axis) and scales the axis, then hands it to a short queue.
// The back end is a sequencer around one shared iterative square-root unit
// and a restoring divider. It normalizes the axis, projects the sphere center,
// tests the off-axis distance and emits one or two result beats.
// Result channel: the oldest result is on the ports while empty is low and is
// taken at a rising edge with pop high. A result queue decouples the back end
// from the receiver, so the front can keep accepting while results wait.
// A rejected item (bad radius or zero axis) skips the back-end arithmetic and
// goes straight to its result beat. A two-circle item's time in the back end
// is set mostly by two square-root waits and three divides. Items are worked
// one at a time in the back end.
// When the receiver stalls the result queue fills, the back end holds its
// beat, the middle queue fills and full rises. Reset empties both queues,
// returns the sequencer to idle and sets the tolerance register to 66.
// The tolerance register may be written only while the block is idle.
module sphere_cylinder_coaxial_intersect_unit
  import scci_pkg::*;
#(
  parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] sphere_center_x,
  input  logic signed [31:0] sphere_center_y,
  input  logic signed [31:0] sphere_center_z,
  input  logic signed [31:0] sphere_rad,
  input  logic signed [31:0] cyl_origin_x,
  input  logic signed [31:0] cyl_origin_y,
  input  logic signed [31:0] cyl_origin_z,
  input  logic signed [31:0] axis_dir_x,
  input  logic signed [31:0] axis_dir_y,
  input  logic signed [31:0] axis_dir_z,
  input  logic signed [31:0] cyl_rad,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic signed [31:0] circle_center_x,
  output logic signed [31:0] circle_center_y,
  output logic signed [31:0] circle_center_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [30:0]        circle_rad,
  output logic               last,
  input  logic               fuzzy_tolerance_we,
  input  logic [30:0]        fuzzy_tolerance
);
  logic [30:0] tol;
  raw_item_t   raw;
  front_item_t front_item;
  front_item_t mid_item;
  logic        front_valid;
  logic        mid_full;
  logic        mid_empty;
  logic        mid_pop;
  logic        res_full;
  logic        res_push;
  result_t     res_in;
  result_t     res_out;

  // The tolerance is a plain register; the back end reads it while it works, so
  // the user must write it only while no item is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (fuzzy_tolerance_we) begin
      tol <= fuzzy_tolerance;
    end
  end

  assign raw.sc = {sphere_center_z, sphere_center_y, sphere_center_x};
  assign raw.rs = sphere_rad;
  assign raw.co = {cyl_origin_z, cyl_origin_y, cyl_origin_x};
  assign raw.ax = {axis_dir_z, axis_dir_y, axis_dir_x};
  assign raw.rc = cyl_rad;

  scci_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .raw(raw),
    .out_valid(front_valid), .out_ready(!mid_full), .item(front_item)
  );

  scci_queue #(.WIDTH($bits(front_item_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst(rst), .push(front_valid), .full(mid_full),
    .wdata(front_item), .pop(mid_pop), .empty(mid_empty), .rdata(mid_item)
  );

  scci_back u_back (
    .clk(clk), .rst(rst), .tol(tol), .mid_empty(mid_empty), .mid_pop(mid_pop),
    .mid(mid_item), .res_full(res_full), .res_push(res_push), .res(res_in)
  );

  scci_queue #(.WIDTH($bits(result_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk(clk), .rst(rst), .push(res_push), .full(res_full),
    .wdata(res_in), .pop(pop), .empty(empty), .rdata(res_out)
  );

  assign status          = res_out.status;
  assign circle_center_x = res_out.cen[0];
  assign circle_center_y = res_out.cen[1];
  assign circle_center_z = res_out.cen[2];
  assign normal_x        = res_out.nrm[0];
  assign normal_y        = res_out.nrm[1];
  assign normal_z        = res_out.nrm[2];
  assign circle_rad      = res_out.rad;
  assign last            = res_out.last;
endmodule
